// ===== design/lphs_pkg.sv =====
package lphs_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned ADDR_W   = IDX_W + 1;
  localparam int unsigned DEPTH    = 2 * CAPACITY;
  localparam int unsigned CNT_W    = IDX_W + 1;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HDL_W    = 32;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned LIVE_W   = 11;
  localparam int unsigned HANDLE_BITS = 32;
  localparam logic [HDL_W-1:0] HDL_MASK =
    (HANDLE_BITS >= HDL_W) ? {HDL_W{1'b1}} : HDL_W'((64'd1 << HANDLE_BITS) - 64'd1);

  // load limit: count * 10 >= capacity * 6
  localparam int unsigned LIMIT = (CAPACITY * 6 + 9) / 10;

  // multiplicative mix, only the low product bits matter
  localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;
  localparam int unsigned PW = 32 + IDX_W;
  localparam int unsigned HL = (PW + 1) / 2;
  localparam int unsigned HH = PW - HL;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_NULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       tag;
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] hdl;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_LOAD_CHK,
    S_HASH1,
    S_HASH2,
    S_PRB_RD,
    S_PRB_CHK,
    S_RB_CLR,
    S_RB_RD,
    S_RB_CHK,
    S_RB_PRD,
    S_RB_PCHK,
    S_RB_PLACE,
    S_FIN
  } state_e;

endpackage

// ===== design/lphs_ram.sv =====
module lphs_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 98
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/linear_probe_hash_set_top.sv =====
// channel  dir  beat fields (lsb first)                 width
// s_axis   in   command[1:0] key[65:2] handle[97:66]    104
// m_axis   out  status[2:0] found_handle[34:3]          48
//               live_count[45:35]
// one command at a time; each probe step is a read and a check through the slot
// memory, and a hash runs through S_HASH1 and S_HASH2 first (three narrow multipliers).
// lookup and remove: hash, probe steps, finish; insert adds a load check before the hash.
// clear sweeps the active bank; an insert at the load limit first rebuilds into the
// other bank: it clears that bank, then reads each source slot, with hash and
// probe for each live entry.
// after reset a clearing pass over both banks runs with tready low.
// a finished result waits in the output register while the next beat is taken.
module linear_probe_hash_set_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [103:0] s_axis_tdata_i,   // command, key, handle
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [47:0]  m_axis_tdata_o    // status, found_handle, live_count
);

  localparam int unsigned IW = lphs_pkg::IDX_W;
  localparam int unsigned AW = lphs_pkg::ADDR_W;
  localparam int unsigned CW = lphs_pkg::CNT_W;
  localparam int unsigned HL = lphs_pkg::HL;
  localparam int unsigned HH = lphs_pkg::HH;
  localparam int unsigned PW = lphs_pkg::PW;
  localparam logic [IW-1:0] LAST_IDX = IW'(lphs_pkg::CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C    = CW'(lphs_pkg::CAPACITY);
  localparam logic [CW:0]   LIMIT_C  = (CW + 1)'(lphs_pkg::LIMIT);

  lphs_pkg::state_e state_q, state_d;

  lphs_pkg::cmd_e               cmd_q, cmd_d;
  logic [lphs_pkg::KEY_W-1:0]   key_q, key_d;
  logic [lphs_pkg::HDL_W-1:0]   hdl_q, hdl_d;
  logic                         bank_q, bank_d;
  logic [CW-1:0]                live_q, live_d;
  logic [CW-1:0]                tomb_q, tomb_d;
  logic [CW-1:0]                rbcnt_q, rbcnt_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic [CW-1:0]                step_q, step_d;
  logic [AW-1:0]                cnt_q, cnt_d;
  logic                         rb_q, rb_d;
  logic [lphs_pkg::KEY_W-1:0]   hkey_q, hkey_d;
  logic [PW-1:0]                pp0_q;
  logic [HH-1:0]                cross_q;
  lphs_pkg::entry_t             ent_q, ent_d;
  lphs_pkg::status_e            status_q, status_d;
  logic [lphs_pkg::HDL_W-1:0]   found_q, found_d;

  logic                         ovalid_q, ovalid_d;
  logic [47:0]                  odata_q, odata_d;

  logic                         we, re;
  logic [AW-1:0]                waddr, raddr;
  lphs_pkg::entry_t             wentry, rentry;
  logic [lphs_pkg::ENTRY_W-1:0] rdata;

  lphs_ram #(
    .DEPTH (lphs_pkg::DEPTH),
    .WIDTH (lphs_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rentry = lphs_pkg::entry_t'(rdata);

  // hash partial products
  logic [HL-1:0]   klo, clo;
  logic [HH-1:0]   khi, chi;
  logic [2*HL-1:0] pp0_full;
  logic [HH-1:0]   cross_c;
  logic [PW-1:0]   prod;
  logic [IW-1:0]   hash_idx;

  assign klo      = hkey_q[HL-1:0];
  assign khi      = hkey_q[PW-1:HL];
  assign clo      = lphs_pkg::HASH_MUL[HL-1:0];
  assign chi      = lphs_pkg::HASH_MUL[PW-1:HL];
  assign pp0_full = klo * clo;
  assign cross_c  = HH'(klo[HH-1:0] * chi) + HH'(khi * clo[HH-1:0]);
  assign prod     = pp0_q + {cross_q, {HL{1'b0}}};
  assign hash_idx = prod[IW-1:0] ^ prod[32 +: IW];

  logic          accept;
  logic [CW:0]   load_sum;
  logic [IW-1:0] idx_inc;
  logic [CW-1:0] step_inc;
  logic          key_hit;

  assign s_axis_tready_o = (state_q == lphs_pkg::S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load_sum        = {1'b0, live_q} + {1'b0, tomb_q};
  assign idx_inc         = idx_q + IW'(1);
  assign step_inc        = step_q + CW'(1);
  assign key_hit         = (rentry.key == key_q);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    hdl_d    = hdl_q;
    bank_d   = bank_q;
    live_d   = live_q;
    tomb_d   = tomb_q;
    rbcnt_d  = rbcnt_q;
    idx_d    = idx_q;
    step_d   = step_q;
    cnt_d    = cnt_q;
    rb_d     = rb_q;
    hkey_d   = hkey_q;
    ent_d    = ent_q;
    status_d = status_q;
    found_d  = found_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    odata_d  = odata_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = {bank_q, idx_q};
    raddr    = {bank_q, idx_q};
    wentry   = '{tag: lphs_pkg::TAG_EMPTY, key: key_q, hdl: hdl_q};

    case (state_q)
      lphs_pkg::S_INIT: begin
        we    = 1'b1;
        waddr = cnt_q;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == {AW{1'b1}}) begin
          state_d = lphs_pkg::S_IDLE;
        end
      end

      lphs_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d    = lphs_pkg::cmd_e'(s_axis_tdata_i[1:0]);
          key_d    = s_axis_tdata_i[65:2];
          hdl_d    = s_axis_tdata_i[97:66] & lphs_pkg::HDL_MASK;
          hkey_d   = s_axis_tdata_i[65:2];
          found_d  = '0;
          status_d = lphs_pkg::ST_OK;
          rb_d     = 1'b0;
          cnt_d    = '0;
          case (lphs_pkg::cmd_e'(s_axis_tdata_i[1:0]))
            lphs_pkg::CMD_CLEAR: state_d = lphs_pkg::S_CLR;
            lphs_pkg::CMD_INSERT: begin
              if ((s_axis_tdata_i[97:66] & lphs_pkg::HDL_MASK) == '0) begin
                status_d = lphs_pkg::ST_NULL;
                state_d  = lphs_pkg::S_FIN;
              end else if (load_sum >= LIMIT_C) begin
                rbcnt_d = '0;
                state_d = lphs_pkg::S_RB_CLR;
              end else begin
                state_d = lphs_pkg::S_LOAD_CHK;
              end
            end
            default: state_d = lphs_pkg::S_HASH1;
          endcase
        end
      end

      lphs_pkg::S_CLR: begin
        we    = 1'b1;
        waddr = {bank_q, cnt_q[IW-1:0]};
        cnt_d = cnt_q + AW'(1);
        if (cnt_q[IW-1:0] == LAST_IDX) begin
          live_d  = '0;
          tomb_d  = '0;
          state_d = lphs_pkg::S_FIN;
        end
      end

      lphs_pkg::S_LOAD_CHK: begin
        if ({1'b0, live_q} >= LIMIT_C) begin
          status_d = lphs_pkg::ST_FULL;
          state_d  = lphs_pkg::S_FIN;
        end else begin
          hkey_d  = key_q;
          rb_d    = 1'b0;
          state_d = lphs_pkg::S_HASH1;
        end
      end

      lphs_pkg::S_HASH1: state_d = lphs_pkg::S_HASH2;

      lphs_pkg::S_HASH2: begin
        idx_d   = hash_idx;
        step_d  = '0;
        state_d = rb_q ? lphs_pkg::S_RB_PRD : lphs_pkg::S_PRB_RD;
      end

      lphs_pkg::S_PRB_RD: begin
        re      = 1'b1;
        state_d = lphs_pkg::S_PRB_CHK;
      end

      lphs_pkg::S_PRB_CHK: begin
        if (cmd_q == lphs_pkg::CMD_INSERT) begin
          if (rentry.tag == lphs_pkg::TAG_LIVE) begin
            if (key_hit) begin
              status_d = lphs_pkg::ST_DUP;
              state_d  = lphs_pkg::S_FIN;
            end else if (step_inc == CAP_C) begin
              status_d = lphs_pkg::ST_FULL;
              state_d  = lphs_pkg::S_FIN;
            end else begin
              idx_d   = idx_inc;
              step_d  = step_inc;
              state_d = lphs_pkg::S_PRB_RD;
            end
          end else begin
            we         = 1'b1;
            wentry.tag = lphs_pkg::TAG_LIVE;
            if (rentry.tag == lphs_pkg::TAG_TOMB && tomb_q != '0) begin
              tomb_d = tomb_q - CW'(1);
            end
            live_d  = live_q + CW'(1);
            state_d = lphs_pkg::S_FIN;
          end
        end else begin
          if (rentry.tag != lphs_pkg::TAG_LIVE && rentry.tag != lphs_pkg::TAG_TOMB) begin
            status_d = lphs_pkg::ST_NOTFOUND;
            state_d  = lphs_pkg::S_FIN;
          end else if (rentry.tag == lphs_pkg::TAG_LIVE && key_hit) begin
            found_d = rentry.hdl;
            state_d = lphs_pkg::S_FIN;
            if (cmd_q == lphs_pkg::CMD_REMOVE) begin
              we         = 1'b1;
              wentry.tag = lphs_pkg::TAG_TOMB;
              wentry.hdl = '0;
              if (live_q != '0) begin
                live_d = live_q - CW'(1);
              end
              tomb_d = tomb_q + CW'(1);
            end
          end else if (step_inc == CAP_C) begin
            status_d = lphs_pkg::ST_NOTFOUND;
            state_d  = lphs_pkg::S_FIN;
          end else begin
            idx_d   = idx_inc;
            step_d  = step_inc;
            state_d = lphs_pkg::S_PRB_RD;
          end
        end
      end

      // rebuild: clear the other bank, then move each live entry across
      lphs_pkg::S_RB_CLR: begin
        we    = 1'b1;
        waddr = {!bank_q, cnt_q[IW-1:0]};
        cnt_d = cnt_q + AW'(1);
        if (cnt_q[IW-1:0] == LAST_IDX) begin
          cnt_d   = '0;
          state_d = lphs_pkg::S_RB_RD;
        end
      end

      lphs_pkg::S_RB_RD: begin
        re      = 1'b1;
        raddr   = {bank_q, cnt_q[IW-1:0]};
        state_d = lphs_pkg::S_RB_CHK;
      end

      lphs_pkg::S_RB_CHK: begin
        if (rentry.tag == lphs_pkg::TAG_LIVE) begin
          ent_d   = rentry;
          hkey_d  = rentry.key;
          rb_d    = 1'b1;
          state_d = lphs_pkg::S_HASH1;
        end else if (cnt_q[IW-1:0] == LAST_IDX) begin
          bank_d  = !bank_q;
          live_d  = rbcnt_q;
          tomb_d  = '0;
          state_d = lphs_pkg::S_LOAD_CHK;
        end else begin
          cnt_d   = cnt_q + AW'(1);
          state_d = lphs_pkg::S_RB_RD;
        end
      end

      lphs_pkg::S_RB_PRD: begin
        re      = 1'b1;
        raddr   = {!bank_q, idx_q};
        state_d = lphs_pkg::S_RB_PCHK;
      end

      lphs_pkg::S_RB_PCHK: begin
        if (rentry.tag == lphs_pkg::TAG_LIVE) begin
          idx_d   = idx_inc;
          step_d  = step_inc;
          state_d = (step_inc == CAP_C) ? lphs_pkg::S_RB_PLACE : lphs_pkg::S_RB_PRD;
        end else begin
          state_d = lphs_pkg::S_RB_PLACE;
        end
      end

      lphs_pkg::S_RB_PLACE: begin
        we         = 1'b1;
        waddr      = {!bank_q, idx_q};
        wentry     = ent_q;
        wentry.tag = lphs_pkg::TAG_LIVE;
        rbcnt_d    = rbcnt_q + CW'(1);
        if (cnt_q[IW-1:0] == LAST_IDX) begin
          bank_d  = !bank_q;
          live_d  = rbcnt_q + CW'(1);
          tomb_d  = '0;
          state_d = lphs_pkg::S_LOAD_CHK;
        end else begin
          cnt_d   = cnt_q + AW'(1);
          state_d = lphs_pkg::S_RB_RD;
        end
      end

      lphs_pkg::S_FIN: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          odata_d  = {2'b00, live_q, found_q, status_q};
          state_d  = lphs_pkg::S_IDLE;
        end
      end

      default: state_d = lphs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lphs_pkg::S_INIT;
      bank_q   <= 1'b0;
      live_q   <= '0;
      tomb_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      bank_q   <= bank_d;
      live_q   <= live_d;
      tomb_q   <= tomb_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    hdl_q    <= hdl_d;
    rbcnt_q  <= rbcnt_d;
    idx_q    <= idx_d;
    step_q   <= step_d;
    rb_q     <= rb_d;
    hkey_q   <= hkey_d;
    ent_q    <= ent_d;
    status_q <= status_d;
    found_q  <= found_d;
    odata_q  <= odata_d;
    pp0_q    <= pp0_full[PW-1:0];
    cross_q  <= cross_c;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule

// ===== sim/linear_probe_hash_set_top_tb.sv =====
module linear_probe_hash_set_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = lphs_pkg::CAPACITY;
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  pad;
    logic [10:0] live_count;
    logic [31:0] found_handle;
    logic [2:0]  status;
  } reply_t;

  // slot-accurate copy of the table, since probe order decides some results
  class hash_set_scoreboard;
    bit [1:0]    tag_mem [2*SLOTS];
    bit [63:0]   key_mem [2*SLOTS];
    bit [31:0]   hdl_mem [2*SLOTS];
    int unsigned bank;
    int unsigned live;
    int unsigned tomb;
    reply_t      pending_replies [$];
    int unsigned mismatches;

    function int unsigned home_slot(logic [63:0] key);
      logic [63:0] p;
      p = key * lphs_pkg::HASH_MUL;
      p = p ^ (p >> 32);
      return 32'(p % 64'(SLOTS));
    endfunction

    function int unsigned next_slot(int unsigned i);
      return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    function int find_live(logic [63:0] key);
      int unsigned base;
      int unsigned i;
      int unsigned a;
      base = bank * SLOTS;
      i = home_slot(key);
      for (int unsigned n = 0; n < SLOTS; n++) begin
        a = base + i;
        if (tag_mem[a] != lphs_pkg::TAG_LIVE && tag_mem[a] != lphs_pkg::TAG_TOMB) return -1;
        if (tag_mem[a] == lphs_pkg::TAG_LIVE && key_mem[a] == key) return int'(a);
        i = next_slot(i);
      end
      return -1;
    endfunction

    function void rebuild();
      int unsigned src;
      int unsigned dst;
      int unsigned i;
      int unsigned n;
      int unsigned count;
      src = bank * SLOTS;
      dst = (bank ^ 1) * SLOTS;
      count = 0;
      for (int unsigned s = 0; s < SLOTS; s++) tag_mem[dst + s] = lphs_pkg::TAG_EMPTY;
      for (int unsigned s = 0; s < SLOTS; s++) begin
        if (tag_mem[src + s] == lphs_pkg::TAG_LIVE) begin
          i = home_slot(key_mem[src + s]);
          n = 0;
          while (n < SLOTS && tag_mem[dst + i] == lphs_pkg::TAG_LIVE) begin
            i = next_slot(i);
            n++;
          end
          tag_mem[dst + i] = lphs_pkg::TAG_LIVE;
          key_mem[dst + i] = key_mem[src + s];
          hdl_mem[dst + i] = hdl_mem[src + s];
          count++;
        end
      end
      bank = bank ^ 1;
      live = count;
      tomb = 0;
    endfunction

    function void note_command(lphs_pkg::cmd_e cmd, logic [63:0] key, logic [31:0] hdl);
      reply_t      r;
      int          a;
      int unsigned base;
      int unsigned i;
      int unsigned s;
      bit          placed;
      r = '0;
      r.status = lphs_pkg::ST_OK;
      case (cmd)
        lphs_pkg::CMD_LOOKUP: begin
          a = find_live(key);
          if (a < 0) r.status = lphs_pkg::ST_NOTFOUND;
          else r.found_handle = hdl_mem[a];
        end
        lphs_pkg::CMD_INSERT: begin
          if (hdl == '0) begin
            r.status = lphs_pkg::ST_NULL;
          end else begin
            if ((live + tomb) * 10 >= SLOTS * 6) rebuild();
            base = bank * SLOTS;
            if (live * 10 >= SLOTS * 6) begin
              r.status = lphs_pkg::ST_FULL;
            end else begin
              i = home_slot(key);
              placed = 1'b0;
              for (int unsigned n = 0;
                   n < SLOTS && !placed && r.status == lphs_pkg::ST_OK; n++) begin
                s = base + i;
                if (tag_mem[s] == lphs_pkg::TAG_LIVE) begin
                  if (key_mem[s] == key) r.status = lphs_pkg::ST_DUP;
                  else i = next_slot(i);
                end else begin
                  // first non-live slot takes the entry, tombstone or not
                  if (tag_mem[s] == lphs_pkg::TAG_TOMB && tomb > 0) tomb--;
                  tag_mem[s] = lphs_pkg::TAG_LIVE;
                  key_mem[s] = key;
                  hdl_mem[s] = hdl;
                  live++;
                  placed = 1'b1;
                end
              end
              if (!placed && r.status == lphs_pkg::ST_OK) r.status = lphs_pkg::ST_FULL;
            end
          end
        end
        lphs_pkg::CMD_REMOVE: begin
          a = find_live(key);
          if (a < 0) begin
            r.status = lphs_pkg::ST_NOTFOUND;
          end else begin
            r.found_handle = hdl_mem[a];
            tag_mem[a] = lphs_pkg::TAG_TOMB;
            hdl_mem[a] = '0;
            if (live > 0) live--;
            tomb++;
          end
        end
        default: begin
          base = bank * SLOTS;
          for (int unsigned c = 0; c < SLOTS; c++) tag_mem[base + c] = lphs_pkg::TAG_EMPTY;
          live = 0;
          tomb = 0;
        end
      endcase
      r.live_count = 11'(live);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp = pending_replies.pop_front();
      if (got.status !== exp.status || got.found_handle !== exp.found_handle ||
          got.live_count !== exp.live_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d hdl=%h live=%0d got st=%0d hdl=%h live=%0d",
                   exp.status, exp.found_handle, exp.live_count,
                   got.status, got.found_handle, got.live_count);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [47:0]  m_axis_tdata_o;

  hash_set_scoreboard sb = new();
  logic [63:0] used_keys [$];
  int unsigned idle_cycles = 0;
  logic        sink_quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  linear_probe_hash_set_top dut (.*);

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    return rand_key();
  endfunction

  // valid stays high between back to back beats
  task automatic send_command(lphs_pkg::cmd_e cmd, logic [63:0] key, logic [31:0] hdl,
                              bit no_gap = 0);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, hdl, key, 2'(cmd)};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(cmd, key, hdl);
    if (cmd == lphs_pkg::CMD_INSERT && hdl != '0 && used_keys.size() < 4000)
      used_keys.push_back(key);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // result side: random back-pressure, with quiet stretches of full readiness
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_reply(reply_t'(m_axis_tdata_o));
    if (sink_quiet) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= (gap_len() == 0);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [63:0] k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, null handle, duplicate, miss, remove, clear
    send_command(lphs_pkg::CMD_LOOKUP, 64'd0, 32'd0);
    send_command(lphs_pkg::CMD_INSERT, 64'd0, 32'hFFFF_FFFF);
    send_command(lphs_pkg::CMD_INSERT, '1, 32'd1);
    send_command(lphs_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 32'd0);
    send_command(lphs_pkg::CMD_INSERT, 64'd0, 32'h1234_5678);
    send_command(lphs_pkg::CMD_LOOKUP, 64'd0, 32'd0);
    send_command(lphs_pkg::CMD_LOOKUP, '1, '1);
    send_command(lphs_pkg::CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 1);
    send_command(lphs_pkg::CMD_REMOVE, 64'd0, 32'd0, 1);
    send_command(lphs_pkg::CMD_REMOVE, 64'd0, 32'd0);
    send_command(lphs_pkg::CMD_LOOKUP, 64'd0, 32'd0);
    send_command(lphs_pkg::CMD_INSERT, 64'd0, 32'h8000_0000);
    send_command(lphs_pkg::CMD_LOOKUP, 64'd0, 32'd0);
    send_command(lphs_pkg::CMD_CLEAR, '1, '1);
    send_command(lphs_pkg::CMD_LOOKUP, '1, 32'd0);
    send_command(lphs_pkg::CMD_INSERT, 64'h8000_0000_0000_0001, 32'h0000_0001);
    send_command(lphs_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0001, 32'd0);

    // hold off until everything has come back
    wait_drained();
    used_keys.delete();

    // fill to the limit with lookups and removes mixed in: rebuild, then full
    sink_quiet <= 1'b1;
    for (int unsigned n = 0; n < 660; n++) begin
      k = (n % 20 == 19) ? pick_key() : rand_key();
      send_command(lphs_pkg::CMD_INSERT, k, $urandom() | 32'd1, n % 8 != 0);
      if (n % 15 == 14) send_command(lphs_pkg::CMD_LOOKUP, pick_key(), 32'd0);
      if (n % 30 == 29) send_command(lphs_pkg::CMD_REMOVE, pick_key(), 32'd0);
      if (n == 330) sink_quiet <= 1'b0;
    end
    send_command(lphs_pkg::CMD_CLEAR, 64'd0, 32'd0);
    send_command(lphs_pkg::CMD_LOOKUP, pick_key(), 32'd0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/lphs_pkg.sv
design/lphs_ram.sv
design/linear_probe_hash_set_top.sv
sim/linear_probe_hash_set_top_tb.sv
